>>> rtl/u8smc_pkg.sv
`timescale 1ns / 1ps

package u8smc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int PEND_W      = 2;
    localparam int LANG_W      = 3;
    localparam int THR_W       = 10;
    localparam int OUT_COUNT_W = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 10;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LANGUAGE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD       = 1'd1;

    // target language codes
    localparam logic [LANG_W-1:0] LANG_KOREAN   = 3'd0;
    localparam logic [LANG_W-1:0] LANG_JAPANESE = 3'd1;
    localparam logic [LANG_W-1:0] LANG_CHINESE  = 3'd2;
    localparam logic [LANG_W-1:0] LANG_THAI     = 3'd3;
    localparam logic [LANG_W-1:0] LANG_LATIN    = 3'd4;
    localparam logic [LANG_W-1:0] LANG_ANY      = 3'd5;

    localparam logic [THR_W-1:0] THR_RESET = 10'd150;

    // script classes
    localparam logic [2:0] CLS_LATIN  = 3'd0;
    localparam logic [2:0] CLS_HANGUL = 3'd1;
    localparam logic [2:0] CLS_HAN    = 3'd2;
    localparam logic [2:0] CLS_KANA   = 3'd3;
    localparam logic [2:0] CLS_THAI   = 3'd4;
    localparam logic [2:0] CLS_JAMO   = 3'd5;
    localparam logic [2:0] CLS_OTHER  = 3'd6;

    typedef struct packed {
        logic letter;
        logic foreign;
    } cls_flags_t;

endpackage

>>> rtl/u8smc_classify.sv
`timescale 1ns / 1ps

module u8smc_classify (
    input  logic [u8smc_pkg::CP_W-1:0]   cp,
    input  logic [u8smc_pkg::LANG_W-1:0] lang,
    output u8smc_pkg::cls_flags_t        flags
);
    import u8smc_pkg::*;

    logic [2:0] cls;
    logic       ok;

    function automatic logic in_rng(input logic [CP_W-1:0] v,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    always_comb
    begin
        if (in_rng(cp, 21'h41, 21'h5A) || in_rng(cp, 21'h61, 21'h7A) ||
            in_rng(cp, 21'h00C0, 21'h024F) || in_rng(cp, 21'h1E00, 21'h1EFF))
            cls = CLS_LATIN;
        else if (in_rng(cp, 21'hAC00, 21'hD7AF))
            cls = CLS_HANGUL;
        else if (in_rng(cp, 21'h1100, 21'h11FF) || in_rng(cp, 21'h3130, 21'h318F) ||
                 in_rng(cp, 21'hA960, 21'hA97F) || in_rng(cp, 21'hD7B0, 21'hD7FF))
            cls = CLS_JAMO;
        else if (in_rng(cp, 21'h4E00, 21'h9FFF) || in_rng(cp, 21'h3400, 21'h4DBF) ||
                 in_rng(cp, 21'hF900, 21'hFAFF))
            cls = CLS_HAN;
        else if (in_rng(cp, 21'h3040, 21'h30FF) || in_rng(cp, 21'h31F0, 21'h31FF))
            cls = CLS_KANA;
        else if (in_rng(cp, 21'h0E00, 21'h0E7F))
            cls = CLS_THAI;
        else
            cls = CLS_OTHER;
    end

    always_comb
    begin
        case (lang)
            LANG_KOREAN:   ok = (cls == CLS_HANGUL);
            LANG_JAPANESE: ok = (cls == CLS_KANA) || (cls == CLS_HAN);
            LANG_CHINESE:  ok = (cls == CLS_HAN);
            LANG_THAI:     ok = (cls == CLS_THAI);
            LANG_LATIN:    ok = (cls == CLS_LATIN);
            LANG_ANY:      ok = 1'b1;
            default:       ok = 1'b1;
        endcase
        // jamo is never allowed
        if (cls == CLS_JAMO)
            ok = 1'b0;
    end

    assign flags.letter  = (cls != CLS_OTHER);
    assign flags.foreign = (cls != CLS_OTHER) && !ok;

endmodule

>>> rtl/utf8_script_mix_counter.sv
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata = text_byte, tlast = is_last
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = letter/foreign counts, tuser = too_foreign
// cfg       in   cfg_we (no wait)               cfg_addr = register index, cfg_wdata
//
// one byte per cycle while s_axis_tready is high: decode, script classification and counter update all
// happen in the cycle a byte is accepted, against the decoder state registers
// a last byte produces one result through the registered count capture, multiply and compare stages
// rst_n clears decoder state, counters and the pipeline valids; registers go to
// target_language = 4 (latin) and threshold_permille = 150
// a stalled result holds the output; input keeps flowing while an upstream stage
// is empty, and stops only when all three result stages are full

module utf8_script_mix_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] text_byte
    input  logic                               s_axis_tlast,   // is_last

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // [15:0] letter_count, [31:16] foreign_count
    output logic                               m_axis_tuser,   // [0] too_foreign

    input  logic                               cfg_we,
    input  logic [u8smc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [u8smc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import u8smc_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + THR_W;
    localparam int EXT_W  = COUNT_WIDTH + OUT_COUNT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [EXT_W-1:0]       OUT_MAX = EXT_W'({OUT_COUNT_W{1'b1}});
    localparam logic [PROD_W-1:0]      PERMILLE = PROD_W'(1000);

    // config registers
    logic [LANG_W-1:0]       lang_reg;
    logic [THR_W-1:0]        thr_reg;

    // decoder state and running counts
    logic [CP_W-1:0]         partial_reg;
    logic [PEND_W-1:0]       pend_reg;
    logic [COUNT_WIDTH-1:0]  letters_reg;
    logic [COUNT_WIDTH-1:0]  foreign_reg;

    // result pipeline
    logic                    s1_valid_reg;
    logic [COUNT_WIDTH-1:0]  s1_letters_reg;
    logic [COUNT_WIDTH-1:0]  s1_foreign_reg;
    logic                    s2_valid_reg;
    logic [COUNT_WIDTH-1:0]  s2_letters_reg;
    logic [COUNT_WIDTH-1:0]  s2_foreign_reg;
    logic [PROD_W-1:0]       s2_fprod_reg;
    logic [PROD_W-1:0]       s2_tprod_reg;
    logic                    out_valid_reg;
    logic [OUT_COUNT_W-1:0]  out_letters_reg;
    logic [OUT_COUNT_W-1:0]  out_foreign_reg;
    logic                    out_flag_reg;

    logic [BYTE_W-1:0]       b;
    logic [CP_W-1:0]         cp_next;
    logic [PEND_W-1:0]       pend_next;
    logic                    count_en;
    cls_flags_t              flags;
    logic [COUNT_WIDTH-1:0]  letters_next;
    logic [COUNT_WIDTH-1:0]  foreign_next;
    logic                    accept;
    logic                    load1;
    logic                    ready2;
    logic                    ready3;
    logic [EXT_W-1:0]        l_ext;
    logic [EXT_W-1:0]        f_ext;

    assign b = s_axis_tdata;

    // loose utf-8 decode of one byte
    always_comb
    begin
        if (pend_reg != '0)
        begin
            cp_next   = {partial_reg[CP_W-7:0], b[5:0]};
            pend_next = pend_reg - PEND_W'(1);
        end
        else if (b < 8'h80)
        begin
            cp_next   = CP_W'(b);
            pend_next = '0;
        end
        else if (b >= 8'hF0)
        begin
            cp_next   = CP_W'(b[2:0]);
            pend_next = PEND_W'(3);
        end
        else if (b >= 8'hE0)
        begin
            cp_next   = CP_W'(b[3:0]);
            pend_next = PEND_W'(2);
        end
        else
        begin
            cp_next   = CP_W'(b[4:0]);
            pend_next = PEND_W'(1);
        end
        // a finished code point, or a cut-off sequence at the end of the text
        count_en = ((pend_next == '0) && ((pend_reg != '0) || (b < 8'h80))) ||
                   (s_axis_tlast && (pend_next != '0));
    end

    u8smc_classify u_classify (
        .cp    (cp_next),
        .lang  (lang_reg),
        .flags (flags)
    );

    // saturating counters
    always_comb
    begin
        letters_next = letters_reg;
        foreign_next = foreign_reg;
        if (count_en && flags.letter && (letters_reg != CNT_MAX))
            letters_next = letters_reg + COUNT_WIDTH'(1);
        if (count_en && flags.foreign && (foreign_reg != CNT_MAX))
            foreign_next = foreign_reg + COUNT_WIDTH'(1);
    end

    assign ready3        = !out_valid_reg || m_axis_tready;
    assign ready2        = !s2_valid_reg || ready3;
    assign s_axis_tready = !s1_valid_reg || ready2;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load1         = accept && s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang_reg <= LANG_LATIN;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET_LANGUAGE: lang_reg <= cfg_wdata[LANG_W-1:0];
                REG_THRESHOLD:       thr_reg  <= cfg_wdata[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pend_reg    <= '0;
            letters_reg <= '0;
            foreign_reg <= '0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                // start the next text clean
                partial_reg <= '0;
                pend_reg    <= '0;
                letters_reg <= '0;
                foreign_reg <= '0;
            end
            else
            begin
                partial_reg <= cp_next;
                pend_reg    <= pend_next;
                letters_reg <= letters_next;
                foreign_reg <= foreign_next;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= load1;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // widen the counts so saturation works for any counter width
    assign l_ext = EXT_W'(s2_letters_reg);
    assign f_ext = EXT_W'(s2_foreign_reg);

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_letters_reg <= letters_next;
            s1_foreign_reg <= foreign_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_letters_reg <= s1_letters_reg;
            s2_foreign_reg <= s1_foreign_reg;
            s2_fprod_reg   <= PROD_W'(s1_foreign_reg) * PERMILLE;
            s2_tprod_reg   <= PROD_W'(thr_reg) * PROD_W'(s1_letters_reg);
        end
        if (ready3 && s2_valid_reg)
        begin
            out_letters_reg <= (l_ext > OUT_MAX) ? {OUT_COUNT_W{1'b1}} : l_ext[OUT_COUNT_W-1:0];
            out_foreign_reg <= (f_ext > OUT_MAX) ? {OUT_COUNT_W{1'b1}} : f_ext[OUT_COUNT_W-1:0];
            out_flag_reg    <= (s2_fprod_reg > s2_tprod_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_foreign_reg, out_letters_reg};
    assign m_axis_tuser  = out_flag_reg;

    // checks

    // a last byte leaves the decoder and counters cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=>
            (letters_reg == '0 && foreign_reg == '0 && pend_reg == '0))
        else $error("state not cleared after last byte");

    // every foreign letter is also a letter
    a_foreign_le_letters: assert property (@(posedge clk) disable iff (!rst_n)
        foreign_reg <= letters_reg)
        else $error("foreign count above letter count");

    // the flag needs at least one foreign letter
    a_flag_needs_foreign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:16] != 16'd0))
        else $error("too_foreign set with no foreign letters");

    // input is held back only when every result stage is occupied
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the result pipeline");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import u8smc_pkg::*;

    localparam int COUNT_W         = 16;
    localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int RESULT_LATENCY  = 3;        // count capture, multiply, compare
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BYTES_PER_PHASE = 45;
    localparam int NUM_PHASES      = 9;
    localparam int PRESSURE_PHASE  = 4;

    // spare language codes, decoded like "any other"
    localparam logic [LANG_W-1:0] LANG_SPARE_6 = 3'd6;
    localparam logic [LANG_W-1:0] LANG_SPARE_7 = 3'd7;

    // phase 0 runs on the reset values, the others rewrite both registers
    localparam logic [LANG_W-1:0] PHASE_LANG [NUM_PHASES] = '{
        LANG_LATIN, LANG_KOREAN, LANG_JAPANESE, LANG_CHINESE, LANG_THAI,
        LANG_ANY, LANG_SPARE_6, LANG_SPARE_7, LANG_LATIN
    };
    // negative means a random threshold
    localparam int PHASE_THR [NUM_PHASES] = '{150, 0, 1000, 1023, -1, -1, -1, -1, -1};

    // code point ranges used to build random text: script blocks, then plain ascii
    // and the rest of the 21-bit space
    localparam int NUM_RANGES = 17;
    localparam int RANGE_LO [NUM_RANGES] = '{
        'h41, 'h61, 'hC0, 'h1E00, 'hAC00, 'h1100, 'h3130, 'hA960, 'hD7B0,
        'h4E00, 'h3400, 'hF900, 'h3040, 'h31F0, 'h0E00, 'h00, 'h80
    };
    localparam int RANGE_HI [NUM_RANGES] = '{
        'h5A, 'h7A, 'h24F, 'h1EFF, 'hD7AF, 'h11FF, 'h318F, 'hA97F, 'hD7FF,
        'h9FFF, 'h4DBF, 'hFAFF, 'h30FF, 'h31FF, 'h0E7F, 'h7F, 'h1FFFFF
    };

    // directed texts as {is_last, byte}:
    // nul + 'A', first hangul syllable, first jamo, lead with an ascii continuation,
    // sequence cut off at the end, 0xFF lead, 0x80 lead, thai, han, kana
    localparam logic [8:0] DIRECTED_BYTES [27] = '{
        9'h000, 9'h141,
        9'h0EA, 9'h0B0, 9'h180,
        9'h0E1, 9'h084, 9'h180,
        9'h0C3, 9'h141,
        9'h0E1, 9'h184,
        9'h0FF, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h080, 9'h180,
        9'h0E0, 9'h0B8, 9'h181,
        9'h0E4, 9'h0B8, 9'h180,
        9'h0E3, 9'h081, 9'h180
    };

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] letters;
        logic [OUT_COUNT_W-1:0] foreign;
        logic                   too_foreign;
    } count_report_t;

    // predicts the per-text counts and checks them in order
    class script_scoreboard;
        logic [LANG_W-1:0] lang;
        logic [THR_W-1:0]  thr;
        logic [CP_W-1:0]   cp_acc;
        logic [PEND_W-1:0] cont_left;
        int unsigned       letters;
        int unsigned       foreign;
        count_report_t     report_q[$];
        int                errors;
        int                checked;
        int                texts;

        function new();
            lang      = LANG_LATIN;
            thr       = THR_RESET;
            cp_acc    = '0;
            cont_left = '0;
            letters   = 0;
            foreign   = 0;
            errors    = 0;
            checked   = 0;
            texts     = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == REG_TARGET_LANGUAGE)
                lang = data[LANG_W-1:0];
            else if (addr == REG_THRESHOLD)
                thr = data[THR_W-1:0];
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function bit between(logic [CP_W-1:0] cp, int lo, int hi);
            return cp >= lo && cp <= hi;
        endfunction

        function logic [2:0] script_of(logic [CP_W-1:0] cp);
            if (between(cp, 'h41, 'h5A) || between(cp, 'h61, 'h7A) ||
                between(cp, 'hC0, 'h24F) || between(cp, 'h1E00, 'h1EFF))
                return CLS_LATIN;
            if (between(cp, 'hAC00, 'hD7AF))
                return CLS_HANGUL;
            if (between(cp, 'h1100, 'h11FF) || between(cp, 'h3130, 'h318F) ||
                between(cp, 'hA960, 'hA97F) || between(cp, 'hD7B0, 'hD7FF))
                return CLS_JAMO;
            if (between(cp, 'h4E00, 'h9FFF) || between(cp, 'h3400, 'h4DBF) ||
                between(cp, 'hF900, 'hFAFF))
                return CLS_HAN;
            if (between(cp, 'h3040, 'h30FF) || between(cp, 'h31F0, 'h31FF))
                return CLS_KANA;
            if (between(cp, 'h0E00, 'h0E7F))
                return CLS_THAI;
            return CLS_OTHER;
        endfunction

        function bit lang_allows(logic [2:0] cls);
            if (cls == CLS_JAMO)
                return 1'b0;
            case (lang)
                LANG_KOREAN:   return cls == CLS_HANGUL;
                LANG_JAPANESE: return cls == CLS_KANA || cls == CLS_HAN;
                LANG_CHINESE:  return cls == CLS_HAN;
                LANG_THAI:     return cls == CLS_THAI;
                LANG_LATIN:    return cls == CLS_LATIN;
                default:       return 1'b1;
            endcase
        endfunction

        function void tally(logic [CP_W-1:0] cp);
            logic [2:0] cls;
            cls = script_of(cp);
            if (cls == CLS_OTHER)
                return;
            if (letters < COUNT_MAX)
                letters++;
            if (!lang_allows(cls) && foreign < COUNT_MAX)
                foreign++;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            count_report_t want;
            if (cont_left != 0)
            begin
                // continuation bits are appended whatever the top bits say
                cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == 0)
                    tally(cp_acc);
            end
            else if (b < 8'h80)
            begin
                cp_acc = CP_W'(b);
                tally(cp_acc);
            end
            else if (b >= 8'hF0)
            begin
                cp_acc    = CP_W'(b[2:0]);
                cont_left = 2'd3;
            end
            else if (b >= 8'hE0)
            begin
                cp_acc    = CP_W'(b[3:0]);
                cont_left = 2'd2;
            end
            else
            begin
                cp_acc    = CP_W'(b[4:0]);
                cont_left = 2'd1;
            end
            if (!last)
                return;
            // a cut-off sequence is classified as gathered so far
            if (cont_left != 0)
                tally(cp_acc);
            want.letters     = (letters > 'hFFFF) ? 16'hFFFF : letters[15:0];
            want.foreign     = (foreign > 'hFFFF) ? 16'hFFFF : foreign[15:0];
            want.too_foreign = longint'(foreign) * 1000 > longint'(thr) * longint'(letters);
            report_q.insert(report_q.size(), want);
            texts++;
            cp_acc    = '0;
            cont_left = '0;
            letters   = 0;
            foreign   = 0;
        endfunction

        function void check_result(logic [31:0] data, logic user);
            count_report_t want;
            if (report_q.size() == 0)
            begin
                $display("%0t: result with none expected: letters %0d foreign %0d flag %0b",
                         $time, data[15:0], data[31:16], user);
                errors++;
                return;
            end
            want = report_q.pop_front();
            checked++;
            if (data[15:0] !== want.letters)
            begin
                $display("%0t: letter_count expected %0d, got %0d",
                         $time, want.letters, data[15:0]);
                errors++;
            end
            if (data[31:16] !== want.foreign)
            begin
                $display("%0t: foreign_count expected %0d, got %0d",
                         $time, want.foreign, data[31:16]);
                errors++;
            end
            if (user !== want.too_foreign)
            begin
                $display("%0t: too_foreign expected %0b, got %0b",
                         $time, want.too_foreign, user);
                errors++;
            end
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;     // [7:0] text_byte
    logic                  s_axis_tlast  = 1'b0;   // is_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;           // [15:0] letter_count, [31:16] foreign_count
    logic                  m_axis_tuser;           // [0] too_foreign
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    script_scoreboard sb = new();

    logic [7:0] text_q[$];        // bytes of the text being sent
    bit         calm          = 1'b0;   // stretch with no idling on either side
    bit         no_gaps       = 1'b0;   // sender runs back to back
    int         hold_off_asks = 0;      // long hold-offs asked of the sink
    int         hold_left     = 0;
    int         stall_left    = 0;
    int         hold_offs     = 0;
    int         bytes_sent    = 0;
    int         reg_writes    = 0;
    int         cycle_count   = 0;

    utf8_script_mix_counter #(
        .COUNT_WIDTH (COUNT_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // toggles between idling and busy stretches
    initial
    begin
        forever
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(40, 400)) @(posedge clk);
        end
    end

    // sink pacing: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_asks != hold_offs)
        begin
            hold_left  = HOLD_OFF_CYCLES;
            stall_left = 0;
            hold_offs++;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // both monitors sample the values present at the edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // one byte request, holds tvalid until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(addr, data);
        reg_writes++;
        @(posedge clk);
    endtask

    // stop offering bytes, let every report out and the pipeline settle;
    // the first edge lets the monitor note the last request
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    // language goes in with junk above bit 2, which the block must ignore
    task automatic set_language(input logic [LANG_W-1:0] lang);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom_range(0, 127) << LANG_W) | CFG_DATA_W'(lang);
        write_reg(REG_TARGET_LANGUAGE, data);
    endtask

    // range edges and their neighbours come up often
    function automatic logic [CP_W-1:0] pick_code_point(int idx);
        int lo;
        int hi;
        int r;
        lo = RANGE_LO[idx];
        hi = RANGE_HI[idx];
        r  = $urandom_range(0, 19);
        if (r == 0 && lo > 0)
            return CP_W'(lo - 1);
        if (r == 1 && hi < 'h1FFFFF)
            return CP_W'(hi + 1);
        if (r < 5)
            return CP_W'(lo);
        if (r < 8)
            return CP_W'(hi);
        return CP_W'($urandom_range(lo, hi));
    endfunction

    // well-formed utf-8, returns the sequence length
    function automatic int append_utf8(logic [CP_W-1:0] cp);
        if (cp < 'h80)
        begin
            text_q.insert(text_q.size(), cp[7:0]);
            return 1;
        end
        if (cp < 'h800)
        begin
            text_q.insert(text_q.size(), {3'b110, cp[10:6]});
            text_q.insert(text_q.size(), {2'b10, cp[5:0]});
            return 2;
        end
        if (cp < 'h10000)
        begin
            text_q.insert(text_q.size(), {4'b1110, cp[15:12]});
            text_q.insert(text_q.size(), {2'b10, cp[11:6]});
            text_q.insert(text_q.size(), {2'b10, cp[5:0]});
            return 3;
        end
        text_q.insert(text_q.size(), {5'b11110, cp[20:18]});
        text_q.insert(text_q.size(), {2'b10, cp[17:12]});
        text_q.insert(text_q.size(), {2'b10, cp[11:6]});
        text_q.insert(text_q.size(), {2'b10, cp[5:0]});
        return 4;
    endfunction

    // mostly one script per text so foreign shares spread over the whole range,
    // with stray raw bytes and now and then a sequence cut at the end
    task automatic build_text();
        int n;
        int home;
        int seq_len;
        int idx;
        text_q.delete();
        n       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        home    = $urandom_range(0, NUM_RANGES - 1);
        seq_len = 1;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                seq_len = 1;
            end
            else
            begin
                idx     = ($urandom_range(0, 9) < 7) ? home : $urandom_range(0, NUM_RANGES - 1);
                seq_len = append_utf8(pick_code_point(idx));
            end
        end
        if (seq_len > 1 && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, seq_len - 1)) void'(text_q.pop_back());
    endtask

    initial
    begin : stimulus
        int phase_start;
        int thr;

        // reset held from time zero, then released on an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts on the reset register values
        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

        // random texts, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                thr = (PHASE_THR[p] < 0) ? $urandom_range(0, 1023) : PHASE_THR[p];
                set_language(PHASE_LANG[p]);
                write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE)
            begin
                build_text();
                send_text();
            end
            if (p == PRESSURE_PHASE)
            begin
                // sink holds off while single-byte texts keep coming,
                // so the result stages fill and the input stalls
                hold_off_asks++;
                no_gaps = 1'b1;
                repeat (40)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                no_gaps = 1'b0;
            end
        end

        drain_results();
        $display("sent %0d bytes in %0d texts, %0d register writes, %0d results checked",
                 bytes_sent, sb.texts, reg_writes, sb.checked);
        $display("all language codes, thresholds 0 to 1023, %0d long sink hold-off",
                 hold_offs);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // run guard
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/u8smc_pkg.sv
rtl/u8smc_classify.sv
rtl/utf8_script_mix_counter.sv
dv/tb.sv
